>>> sv/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  localparam int MODE_W     = 2;
  localparam int ELAPSED_W  = 16;
  localparam int LEVEL_W    = 16;
  localparam int PHASE_W    = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int OUT_FRAC   = 15;

  localparam logic [LEVEL_W-1:0] SUSTAIN_MAX = 16'd32768;

  typedef enum logic [MODE_W-1:0] {
    MD_TICK,
    MD_NOTE_ON,
    MD_NOTE_OFF,
    MD_RESET
  } mode_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ATTACK,
    CFG_DECAY,
    CFG_RELEASE,
    CFG_SUSTAIN
  } cfg_index_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_FIN,
    SQ_DIV,
    SQ_OUT
  } seq_state_t;

endpackage

>>> sv/adsr_in_if.sv
`timescale 1ns / 1ps

interface adsr_in_if import adsr_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [ELAPSED_W-1:0] elapsed;

  modport source (output valid, output mode, output elapsed, input ready);
  modport sink   (input valid, input mode, input elapsed, output ready);

endinterface

>>> sv/adsr_out_if.sv
`timescale 1ns / 1ps

interface adsr_out_if import adsr_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [PHASE_W-1:0] phase;
  logic               active;

  modport source (output valid, output level, output phase, output active, input ready);
  modport sink   (input valid, input level, input phase, input active, output ready);

endinterface

>>> sv/linear_adsr_envelope_top.sv
// jumps go straight to the result register; a tick that ramps the level runs the 16-step
// shift-add multiply, a note-on/off that computes a slope runs the FRACTION_BITS+1 divide
// steps, and a tick that ends the attack runs the multiply, then the divide; all of them run
// on one shared adder. one request at a time, next one taken the cycle after the result is
// registered. synchronous active-low reset: envelope idle at zero, lengths zero, sustain full.
`timescale 1ns / 1ps

module linear_adsr_envelope_top import adsr_pkg::*; #(
  parameter int FRACTION_BITS = 31,
  parameter int TIME_BITS     = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [((TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W)-1:0] cfg_wdata,
  adsr_in_if.sink               in_chan,
  adsr_out_if.source            out_chan
);

  localparam int LVL_W = FRACTION_BITS + 1;
  localparam int ACC_W = FRACTION_BITS + 19;
  localparam int MC_W  = FRACTION_BITS + ELAPSED_W;
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam int SHIFT = FRACTION_BITS - OUT_FRAC;

  localparam logic [LVL_W-1:0]        FULL_SCALE = LVL_W'(1) << FRACTION_BITS;
  localparam logic signed [ACC_W-1:0] FS_ACC     = ACC_W'(FULL_SCALE);

  // configuration
  logic [TIME_BITS-1:0] att_r, dec_r, rel_r;
  logic [LEVEL_W-1:0]   sus_r;

  // sequencer and envelope state
  seq_state_t           seq_r, seq_nxt;
  phase_t               stage_r, stage_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;
  logic [LVL_W-1:0]     slope_mag_r, slope_mag_nxt;
  logic                 slope_neg_r, slope_neg_nxt;

  // shared datapath
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [LVL_W-1:0]        quot_r, quot_nxt;
  logic [MC_W-1:0]         mcand_r, mcand_nxt;
  logic [ELAPSED_W-1:0]    e_r, e_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]    dlen_r, dlen_nxt;
  logic                    nz_r, nz_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  phase_t               out_phase_r, out_phase_nxt;
  logic                 out_active_r, out_active_nxt;

  logic signed [ACC_W-1:0] add_a, add_b, add_sum, rem_shift;
  logic                    add_sub;
  logic [LEVEL_W-1:0]      sus_sat;
  logic [LVL_W-1:0]        sus_fixed;
  logic                    dec_go, div_go, div_neg;
  logic [LVL_W-1:0]        div_dvd;
  logic [TIME_BITS-1:0]    div_len;

  function automatic logic [LVL_W-1:0] clamp(input logic signed [ACC_W-1:0] v);
    logic [LVL_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > FS_ACC) begin
      r = FULL_SCALE;
    end else begin
      r = v[LVL_W-1:0];
    end
    return r;
  endfunction

  assign sus_sat   = (sus_r > SUSTAIN_MAX) ? SUSTAIN_MAX : sus_r;
  assign sus_fixed = LVL_W'(sus_sat) << SHIFT;
  assign add_sum   = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign rem_shift = {acc_r[ACC_W-2:0], quot_r[LVL_W-1]};

  assign in_chan.ready   = (seq_r == SQ_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.level  = out_level_r;
  assign out_chan.phase  = out_phase_r;
  assign out_chan.active = out_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_r <= '0;
      dec_r <= '0;
      rel_r <= '0;
      sus_r <= SUSTAIN_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_ATTACK:  att_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_DECAY:   dec_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_RELEASE: rel_r <= cfg_wdata[TIME_BITS-1:0];
        CFG_SUSTAIN: sus_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_IDLE;
      stage_r     <= PH_IDLE;
      level_r     <= '0;
      slope_mag_r <= '0;
      slope_neg_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      stage_r     <= stage_nxt;
      level_r     <= level_nxt;
      slope_mag_r <= slope_mag_nxt;
      slope_neg_r <= slope_neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    quot_r       <= quot_nxt;
    mcand_r      <= mcand_nxt;
    e_r          <= e_nxt;
    cnt_r        <= cnt_nxt;
    dlen_r       <= dlen_nxt;
    nz_r         <= nz_nxt;
    out_level_r  <= out_level_nxt;
    out_phase_r  <= out_phase_nxt;
    out_active_r <= out_active_nxt;
  end

  always_comb begin
    seq_nxt        = seq_r;
    stage_nxt      = stage_r;
    level_nxt      = level_r;
    slope_mag_nxt  = slope_mag_r;
    slope_neg_nxt  = slope_neg_r;
    acc_nxt        = acc_r;
    quot_nxt       = quot_r;
    mcand_nxt      = mcand_r;
    e_nxt          = e_r;
    cnt_nxt        = cnt_r;
    dlen_nxt       = dlen_r;
    nz_nxt         = nz_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_level_nxt  = out_level_r;
    out_phase_nxt  = out_phase_r;
    out_active_nxt = out_active_r;
    add_a          = '0;
    add_b          = '0;
    add_sub        = 1'b0;
    dec_go         = 1'b0;
    div_go         = 1'b0;
    div_neg        = 1'b0;
    div_dvd        = '0;
    div_len        = '0;

    case (seq_r)
      SQ_IDLE: begin
        if (in_chan.valid) begin
          case (mode_t'(in_chan.mode))
            MD_TICK: begin
              // ramping stages start the shift-add multiply
              acc_nxt   = $signed(ACC_W'(level_r));
              mcand_nxt = MC_W'(slope_mag_r);
              e_nxt     = in_chan.elapsed;
              cnt_nxt   = '0;
              case (stage_r)
                PH_ATTACK: begin
                  if (att_r == '0) begin
                    dec_go = 1'b1;
                  end else begin
                    seq_nxt = SQ_MUL;
                  end
                end
                PH_DECAY: begin
                  if (dec_r != '0) begin
                    seq_nxt = SQ_MUL;
                  end else begin
                    level_nxt     = sus_fixed;
                    stage_nxt     = PH_SUSTAIN;
                    slope_mag_nxt = '0;
                    seq_nxt       = SQ_OUT;
                  end
                end
                PH_SUSTAIN: begin
                  level_nxt = sus_fixed;
                  seq_nxt   = SQ_OUT;
                end
                PH_RELEASE: begin
                  if (rel_r != '0) begin
                    seq_nxt = SQ_MUL;
                  end else begin
                    level_nxt     = '0;
                    stage_nxt     = PH_IDLE;
                    slope_mag_nxt = '0;
                    seq_nxt       = SQ_OUT;
                  end
                end
                default: begin
                  level_nxt = '0;
                  seq_nxt   = SQ_OUT;
                end
              endcase
            end
            MD_NOTE_ON: begin
              stage_nxt = PH_ATTACK;
              if (att_r != '0) begin
                div_go  = 1'b1;
                div_dvd = FULL_SCALE - level_r;
                div_len = att_r;
              end else begin
                level_nxt     = FULL_SCALE;
                slope_mag_nxt = '0;
                seq_nxt       = SQ_OUT;
              end
            end
            MD_NOTE_OFF: begin
              stage_nxt = PH_RELEASE;
              if (rel_r != '0) begin
                div_go  = 1'b1;
                div_neg = 1'b1;
                div_dvd = level_r;
                div_len = rel_r;
              end else begin
                level_nxt     = '0;
                slope_mag_nxt = '0;
                seq_nxt       = SQ_OUT;
              end
            end
            default: begin
              stage_nxt     = PH_IDLE;
              level_nxt     = '0;
              slope_mag_nxt = '0;
              seq_nxt       = SQ_OUT;
            end
          endcase
        end
      end
      SQ_MUL: begin
        add_a     = acc_r;
        add_b     = e_r[0] ? $signed(ACC_W'(mcand_r)) : '0;
        add_sub   = slope_neg_r;
        acc_nxt   = add_sum;
        mcand_nxt = mcand_r << 1;
        e_nxt     = e_r >> 1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ELAPSED_W - 1)) begin
          seq_nxt = SQ_FIN;
        end
      end
      SQ_FIN: begin
        seq_nxt = SQ_OUT;
        case (stage_r)
          PH_ATTACK: begin
            if (acc_r >= FS_ACC) begin
              dec_go = 1'b1;
            end else begin
              level_nxt = clamp(acc_r);
            end
          end
          PH_DECAY: begin
            if (acc_r <= $signed(ACC_W'(sus_fixed))) begin
              level_nxt     = sus_fixed;
              stage_nxt     = PH_SUSTAIN;
              slope_mag_nxt = '0;
            end else begin
              level_nxt = clamp(acc_r);
            end
          end
          PH_RELEASE: begin
            if (acc_r <= 0) begin
              level_nxt     = '0;
              stage_nxt     = PH_IDLE;
              slope_mag_nxt = '0;
            end else begin
              level_nxt = clamp(acc_r);
            end
          end
          default: level_nxt = clamp(acc_r);
        endcase
      end
      SQ_DIV: begin
        // restoring divide, one quotient bit per cycle
        add_a   = rem_shift;
        add_b   = $signed(ACC_W'(dlen_r));
        add_sub = 1'b1;
        if (!add_sum[ACC_W-1]) begin
          acc_nxt  = add_sum;
          quot_nxt = {quot_r[LVL_W-2:0], 1'b1};
        end else begin
          acc_nxt  = rem_shift;
          quot_nxt = {quot_r[LVL_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRACTION_BITS)) begin
          slope_mag_nxt = ((quot_nxt == '0) && nz_r) ? LVL_W'(1) : quot_nxt;
          seq_nxt       = SQ_OUT;
        end
      end
      SQ_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_level_nxt  = level_r[FRACTION_BITS -: LEVEL_W];
          out_phase_nxt  = stage_r;
          out_active_nxt = (stage_r != PH_IDLE);
          seq_nxt        = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase

    // attack done, enter decay
    if (dec_go) begin
      level_nxt = FULL_SCALE;
      stage_nxt = PH_DECAY;
      seq_nxt   = SQ_OUT;
      if (dec_r != '0) begin
        div_go  = 1'b1;
        div_neg = 1'b1;
        div_dvd = FULL_SCALE - sus_fixed;
        div_len = dec_r;
      end else begin
        level_nxt     = sus_fixed;
        slope_mag_nxt = '0;
      end
    end

    if (div_go) begin
      acc_nxt       = '0;
      quot_nxt      = div_dvd;
      nz_nxt        = (div_dvd != '0);
      slope_neg_nxt = div_neg;
      dlen_nxt      = div_len;
      cnt_nxt       = '0;
      seq_nxt       = SQ_DIV;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= FULL_SCALE)
    else $error("envelope level above full scale");

  a_idle_slope: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_IDLE && stage_r == PH_IDLE) |-> (slope_mag_r == '0))
    else $error("idle envelope holds a nonzero slope");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(seq_r == SQ_OUT))
    else $error("result raised outside the output step");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (seq_r != SQ_IDLE))
    else $error("sequencer idle right after a request");

endmodule
